// ===== design/sexpr_tokenizer_validator_assert.svh =====
// Assertion macros for the S-expression tokenizer and validator.
// Included by files that check their own logic; expects aclk and aresetn in scope.
`ifndef SEXPR_TOKENIZER_VALIDATOR_ASSERT_SVH
`define SEXPR_TOKENIZER_VALIDATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/stv_pkg.sv =====
// Shared types and constants of the S-expression tokenizer and validator.
// No dependencies; imported by every module of the block.
package stv_pkg;

    localparam int unsigned MAX_DEPTH    = 255;
    localparam int unsigned MAX_POSITION = 65535;
    localparam int unsigned COL_W        = 16;
    localparam int unsigned DEPTH_W      = 8;
    localparam int unsigned MAX_RES      = 4;
    localparam int unsigned CNT_W        = $clog2(MAX_RES + 1);
    localparam int unsigned IDX_W        = $clog2(MAX_RES);

    typedef enum logic [3:0] {
        K_LPAREN  = 4'd0,
        K_RPAREN  = 4'd1,
        K_INTEGER = 4'd2,
        K_REAL    = 4'd3,
        K_NAME    = 4'd4,
        K_NIL     = 4'd5,
        K_STRING  = 4'd6,
        K_EOF     = 4'd7,
        K_ERROR   = 4'd8
    } kind_t;

    typedef enum logic [3:0] {
        E_NONE          = 4'd0,
        E_BAD_CHAR      = 4'd1,
        E_OPEN_STRING   = 4'd2,
        E_EXTRA_POINT   = 4'd3,
        E_NO_OPEN       = 4'd4,
        E_MISSING_CLOSE = 4'd5,
        E_TRAILING      = 4'd6,
        E_TOO_DEEP      = 4'd7,
        E_TOO_LONG      = 4'd8
    } err_t;

    typedef struct packed {
        logic       end_mark;
        logic [7:0] ch;
    } item_t;

    typedef struct packed {
        kind_t              kind;
        logic [COL_W-1:0]   start_col;
        logic [COL_W-1:0]   token_len;
        logic [DEPTH_W-1:0] nest_level;
        err_t               err_code;
        logic               finished;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0]          cnt;
        result_t [MAX_RES-1:0]     res;
    } bundle_t;

    typedef struct packed {
        logic busy;
        logic step;
    } in_ctl_t;

endpackage

// ===== design/stv_in_stage.sv =====
// Input register of the tokenizer: holds one accepted character beat.
// Depends on stv_pkg.
module stv_in_stage
    import stv_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tlast,   // end_mark
    input  logic       out_free,
    output item_t      item,
    output in_ctl_t    ctl
);

    logic  valid_reg;
    item_t item_reg;

    assign ctl.busy = valid_reg;
    assign ctl.step = valid_reg && out_free;
    assign s_tready = !valid_reg || out_free;
    assign item     = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (ctl.step) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.ch       <= s_tdata;
            item_reg.end_mark <= s_tlast;
        end
    end

endmodule

// ===== design/stv_lexer.sv =====
// Lexer and nesting checker: state registers and the one-character update.
// Depends on stv_pkg; produces the bundle of results for each character.
module stv_lexer
    import stv_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  item_t   item,
    input  logic    step,
    output bundle_t bundle
);

    typedef enum logic [2:0] {LX_IDLE, LX_NAME, LX_NUM, LX_SIGN, LX_STR} lex_t;
    typedef enum logic [1:0] {PP_OPEN, PP_IN, PP_CLOSED, PP_DONE} parse_t;
    typedef enum logic [1:0] {LA_NONE, LA_E, LA_E_SIGN} la_t;
    typedef enum logic [1:0] {NIL_NONE, NIL_N, NIL_NI, NIL_NIL} nil_t;

    typedef struct packed {
        lex_t               lp;
        parse_t             pp;
        logic [COL_W-1:0]   pos;
        logic [COL_W-1:0]   tstart;
        logic [DEPTH_W-1:0] depth;
        logic               pseen;
        logic               eseen;
        la_t                la;
        nil_t               nilp;
    } lex_state_t;

    typedef struct packed {
        lex_state_t s;
        bundle_t    b;
    } work_t;

    localparam int unsigned LEX_PASSES = 3;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LOW_E  = 8'h65;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_I  = 8'h69;
    localparam logic [7:0] CH_LOW_L  = 8'h6C;

    lex_state_t state_reg;
    work_t      w;

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_blank(logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0A;
    endfunction

    function automatic logic is_sign(logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS;
    endfunction

    function automatic lex_state_t reset_state();
        lex_state_t s;
        s        = '0;
        s.lp     = LX_IDLE;
        s.pp     = PP_OPEN;
        s.la     = LA_NONE;
        s.nilp   = NIL_NONE;
        return s;
    endfunction

    // Appends one result if there is room; the nesting level is the depth at this moment, zero for the end report.
    function automatic work_t push(work_t wi, kind_t k, logic [COL_W-1:0] col,
                                   logic [COL_W-1:0] len, err_t e, logic fin);
        work_t r;
        r = wi;
        if (r.b.cnt < CNT_W'(MAX_RES)) begin
            r.b.res[r.b.cnt[IDX_W-1:0]].kind       = k;
            r.b.res[r.b.cnt[IDX_W-1:0]].start_col  = col;
            r.b.res[r.b.cnt[IDX_W-1:0]].token_len  = len;
            r.b.res[r.b.cnt[IDX_W-1:0]].nest_level = (k == K_EOF) ? '0 : r.s.depth;
            r.b.res[r.b.cnt[IDX_W-1:0]].err_code   = e;
            r.b.res[r.b.cnt[IDX_W-1:0]].finished   = fin;
            r.b.cnt = r.b.cnt + CNT_W'(1);
        end
        return r;
    endfunction

    // Only the first error of an expression is reported.
    function automatic work_t fail(work_t wi, err_t e, logic [COL_W-1:0] col);
        work_t r;
        r = wi;
        if (r.s.pp == PP_DONE) return r;
        r = push(r, K_ERROR, col, '0, e, 1'b1);
        r.s.pp = PP_DONE;
        return r;
    endfunction

    function automatic work_t take(work_t wi, kind_t k, logic [COL_W-1:0] col,
                                   logic [COL_W-1:0] len);
        work_t r;
        r = wi;
        if (r.s.pp != PP_IN) return r;
        if (k == K_LPAREN) begin
            if (r.s.depth >= DEPTH_W'(MAX_DEPTH)) return fail(r, E_TOO_DEEP, col);
            r.s.depth = r.s.depth + DEPTH_W'(1);
        end else if (k == K_RPAREN) begin
            if (r.s.depth != '0) r.s.depth = r.s.depth - DEPTH_W'(1);
            if (r.s.depth == '0) r.s.pp = PP_CLOSED;
        end
        return push(r, k, col, len, E_NONE, 1'b0);
    endfunction

    function automatic work_t take_number(work_t wi, logic [COL_W-1:0] last_col);
        return take(wi, (wi.s.pseen || wi.s.eseen) ? K_REAL : K_INTEGER,
                    wi.s.tstart, last_col - wi.s.tstart);
    endfunction

    // One character inside the expression. A token that a character ends is
    // reported first, and the character is then looked at again in the new
    // phase; a number followed by a held exponent marker needs two such rounds.
    function automatic work_t lex_char(work_t wi, logic [7:0] c, logic [COL_W-1:0] col);
        work_t r;
        logic  go;
        r  = wi;
        go = 1'b1;
        for (int p = 0; p < LEX_PASSES; p++) begin
            if (go && r.s.pp == PP_IN) begin
                go = 1'b0;
                case (r.s.lp)
                    LX_IDLE: begin
                        if (is_blank(c)) begin
                        end else if (c == CH_LPAREN) begin
                            r = take(r, K_LPAREN, col, COL_W'(1));
                        end else if (c == CH_RPAREN) begin
                            r = take(r, K_RPAREN, col, COL_W'(1));
                        end else begin
                            r.s.tstart = col;
                            if (is_alpha(c)) begin
                                r.s.lp   = LX_NAME;
                                r.s.nilp = (c == CH_LOW_N) ? NIL_N : NIL_NONE;
                            end else if (is_digit(c)) begin
                                r.s.lp    = LX_NUM;
                                r.s.pseen = 1'b0;
                                r.s.eseen = 1'b0;
                                r.s.la    = LA_NONE;
                            end else if (c == CH_QUOTE) begin
                                r.s.lp = LX_STR;
                            end else if (is_sign(c)) begin
                                r.s.lp = LX_SIGN;
                            end else begin
                                r = fail(r, E_BAD_CHAR, col);
                            end
                        end
                    end
                    LX_NAME: begin
                        if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
                            if (r.s.nilp == NIL_N && c == CH_LOW_I) r.s.nilp = NIL_NI;
                            else if (r.s.nilp == NIL_NI && c == CH_LOW_L) r.s.nilp = NIL_NIL;
                            else r.s.nilp = NIL_NONE;
                        end else begin
                            r.s.lp = LX_IDLE;
                            r = take(r, (r.s.nilp == NIL_NIL) ? K_NIL : K_NAME,
                                     r.s.tstart, col - r.s.tstart);
                            go = 1'b1;
                        end
                    end
                    LX_SIGN: begin
                        if (is_digit(c) || c == CH_POINT) begin
                            r.s.lp    = LX_NUM;
                            r.s.pseen = (c == CH_POINT);
                            r.s.eseen = 1'b0;
                            r.s.la    = LA_NONE;
                        end else begin
                            r = fail(r, E_BAD_CHAR, r.s.tstart);
                        end
                    end
                    LX_STR: begin
                        if (c == CH_QUOTE) begin
                            r.s.lp = LX_IDLE;
                            r = take(r, K_STRING, r.s.tstart,
                                     col - r.s.tstart - COL_W'(1));
                        end
                    end
                    LX_NUM: begin
                        if (r.s.la == LA_E) begin
                            if (is_digit(c)) begin
                                r.s.eseen = 1'b1;
                                r.s.la    = LA_NONE;
                            end else if (is_sign(c)) begin
                                r.s.la = LA_E_SIGN;
                            end else begin
                                // The held 'e' starts a name after all.
                                r.s.la     = LA_NONE;
                                r          = take_number(r, col - COL_W'(1));
                                r.s.lp     = LX_NAME;
                                r.s.tstart = col - COL_W'(1);
                                r.s.nilp   = NIL_NONE;
                                go         = 1'b1;
                            end
                        end else if (r.s.la == LA_E_SIGN) begin
                            if (is_digit(c)) begin
                                r.s.eseen = 1'b1;
                                r.s.la    = LA_NONE;
                            end else begin
                                // The 'e' is a one-letter name and the sign
                                // opens a new signed number.
                                r.s.la     = LA_NONE;
                                r          = take_number(r, col - COL_W'(2));
                                r          = take(r, K_NAME, col - COL_W'(2), COL_W'(1));
                                r.s.lp     = LX_SIGN;
                                r.s.tstart = col - COL_W'(1);
                                go         = 1'b1;
                            end
                        end else if (is_digit(c)) begin
                        end else if (c == CH_POINT) begin
                            if (r.s.pseen || r.s.eseen) r = fail(r, E_EXTRA_POINT, col);
                            else r.s.pseen = 1'b1;
                        end else if ((c == CH_LOW_E || c == CH_UP_E) && !r.s.eseen) begin
                            r.s.la = LA_E;
                        end else begin
                            r.s.lp = LX_IDLE;
                            r      = take_number(r, col);
                            go     = 1'b1;
                        end
                    end
                    default: begin
                        r.s.lp = LX_IDLE;
                    end
                endcase
            end
        end
        return r;
    endfunction

    // Flushes the pending token at the end mark.
    function automatic work_t lex_end(work_t wi);
        work_t            r;
        logic [COL_W-1:0] col;
        r   = wi;
        col = wi.s.pos;
        case (r.s.lp)
            LX_NAME: begin
                r = take(r, (r.s.nilp == NIL_NIL) ? K_NIL : K_NAME,
                         r.s.tstart, col - r.s.tstart);
            end
            LX_SIGN: r = fail(r, E_BAD_CHAR, r.s.tstart);
            LX_STR:  r = fail(r, E_OPEN_STRING, r.s.tstart);
            LX_NUM: begin
                if (r.s.la == LA_E) begin
                    r = take_number(r, col - COL_W'(1));
                    r = take(r, K_NAME, col - COL_W'(1), COL_W'(1));
                end else if (r.s.la == LA_E_SIGN) begin
                    r = take_number(r, col - COL_W'(2));
                    r = take(r, K_NAME, col - COL_W'(2), COL_W'(1));
                    r = fail(r, E_BAD_CHAR, col - COL_W'(1));
                end else begin
                    r = take_number(r, col);
                end
            end
            default: begin
            end
        endcase
        r.s.lp = LX_IDLE;
        return r;
    endfunction

    always_comb begin
        w.s = state_reg;
        w.b = '0;
        if (item.end_mark) begin
            case (state_reg.pp)
                PP_OPEN: w = fail(w, E_NO_OPEN, state_reg.pos);
                PP_IN: begin
                    w = lex_end(w);
                    if (w.s.pp == PP_IN) w = fail(w, E_MISSING_CLOSE, state_reg.pos);
                end
                PP_CLOSED: w = push(w, K_EOF, state_reg.pos, '0, E_NONE, 1'b1);
                default: begin
                end
            endcase
            w.s = reset_state();
        end else if (state_reg.pp != PP_DONE) begin
            if (32'(state_reg.pos) >= 32'(MAX_POSITION)) begin
                w = fail(w, E_TOO_LONG, state_reg.pos);
            end else begin
                case (state_reg.pp)
                    PP_OPEN: begin
                        if (item.ch == CH_LPAREN) begin
                            w.s.depth = DEPTH_W'(1);
                            w.s.pp    = PP_IN;
                            w = push(w, K_LPAREN, state_reg.pos, COL_W'(1), E_NONE, 1'b0);
                        end else if (!is_blank(item.ch)) begin
                            w = fail(w, E_NO_OPEN, state_reg.pos);
                        end
                    end
                    PP_IN: w = lex_char(w, item.ch, state_reg.pos);
                    PP_CLOSED: begin
                        if (!is_blank(item.ch)) w = fail(w, E_TRAILING, state_reg.pos);
                    end
                    default: begin
                    end
                endcase
                w.s.pos = state_reg.pos + COL_W'(1);
            end
        end
    end

    assign bundle = w.b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= reset_state();
        end else if (step) begin
            state_reg <= w.s;
        end
    end

endmodule

// ===== design/stv_out_stage.sv =====
// Result register of the tokenizer: holds the results of one character
// and hands them out one beat at a time. Depends on stv_pkg.
module stv_out_stage
    import stv_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  bundle_t bundle_in,
    output logic    free,
    output logic    valid,
    input  logic    ready,
    output result_t res,
    output logic    last
);

    logic [CNT_W-1:0]      cnt_reg;
    logic [IDX_W-1:0]      idx_reg;
    result_t [MAX_RES-1:0] res_reg;

    assign valid = (cnt_reg != '0);
    assign res   = res_reg[idx_reg];
    assign last  = ({1'b0, idx_reg} == (cnt_reg - CNT_W'(1)));
    assign free  = !valid || (ready && last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else if (free) begin
            if (load) begin
                cnt_reg <= bundle_in.cnt;
            end else begin
                cnt_reg <= '0;
            end
            idx_reg <= '0;
        end else if (ready) begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (free && load) begin
            res_reg <= bundle_in.res;
        end
    end

endmodule

// ===== design/sexpr_tokenizer_validator.sv =====
// Top level of the S-expression tokenizer and validator.
// Depends on stv_pkg, stv_in_stage, stv_lexer, stv_out_stage and the assert header.
//
// One character enters per slave beat: s_tdata carries the byte and s_tlast
// marks the end of the text (the byte is then ignored). Each master beat is one
// token, the end-of-text report or an error: m_tuser gives its kind, m_tdata its
// column, length, nesting depth, error code and the finished flag, and m_tlast
// marks the last result that one character (or the end mark) produced.
// A character is held in the input register and classified there by the
// combinational lexer; its results land in the result register once that is
// free, and the first result of a beat shows on the master side from there.
// The block takes one character per cycle as long as each character yields
// at most one result and the receiver keeps m_tready high; a character that
// yields two or three results at once holds the input back while the single
// result register drains them one result per cycle as m_tready allows.
// After reset the block waits for the opening parenthesis with nothing held.
// When the receiver stalls, the results wait in the result register, the
// input register holds one more character, and s_tready then drops.
// After the first error no results come until the end mark, which returns
// the block to its reset state.
`include "sexpr_tokenizer_validator_assert.svh"

module sexpr_tokenizer_validator
    import stv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // end_mark
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] start_col, [31:16] token_len, [39:32] nest_level,
    // [43:40] err_code, [44] finished, [47:45] zero
    output logic [47:0] m_tdata,
    output logic [3:0]  m_tuser,   // [3:0] kind
    output logic        m_tlast    // last
);

    item_t   item;
    in_ctl_t in_ctl;
    bundle_t bundle;
    logic    out_free;
    result_t out_res;

    stv_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .out_free (out_free),
        .item     (item),
        .ctl      (in_ctl)
    );

    // The lexer state moves on only when the character's results can be
    // parked in the result register.
    stv_lexer u_lexer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item),
        .step    (in_ctl.step),
        .bundle  (bundle)
    );

    stv_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (in_ctl.step),
        .bundle_in (bundle),
        .free      (out_free),
        .valid     (m_tvalid),
        .ready     (m_tready),
        .res       (out_res),
        .last      (m_tlast)
    );

    assign m_tuser = out_res.kind;
    assign m_tdata = {3'b000, out_res.finished, out_res.err_code, out_res.nest_level,
                      out_res.token_len, out_res.start_col};

    // A result that ends the expression is always the final one of its beat.
    `STV_ASSERT_NOW(a_finished_is_last, m_tvalid && out_res.finished, m_tlast,
        "finished result is not the last of its beat")

    // Errors carry a code and end the expression.
    `STV_ASSERT_NOW(a_error_has_code, m_tvalid && out_res.kind == K_ERROR,
        out_res.err_code != E_NONE && out_res.finished,
        "error result without code or finished flag")

    // Tokens and the end report carry no error code.
    `STV_ASSERT_NOW(a_token_no_code, m_tvalid && out_res.kind != K_ERROR,
        out_res.err_code == E_NONE, "non-error result with an error code")

    // A held character is not dropped while the result register is busy.
    `STV_ASSERT_NEXT(a_input_held, in_ctl.busy && !in_ctl.step, in_ctl.busy,
        "held character lost before it was processed")

endmodule

// ===== tb/tb_sexpr_tokenizer_validator.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the S-expression tokenizer and validator.
// Depends on stv_pkg and the sexpr_tokenizer_validator RTL; an internal token
// predictor works out every expected result beat and the monitor compares them.

module tb_sexpr_tokenizer_validator;
    import stv_pkg::*;

    // Timing of the run. The watchdog counts cycles in which neither side
    // moves a beat; the longest correct quiet stretch is the receiver hold.
    localparam int unsigned RESET_CYCLES   = 7;
    localparam int unsigned DRAIN_CYCLES   = 16;
    localparam int unsigned LONG_HOLD      = 150;
    localparam int unsigned HOLD_PERIOD    = 600;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned RANDOM_ITEMS   = 16;
    localparam int unsigned MAX_REPORTS    = 100;

    // Characters that the predictor and the stimulus use by name.
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_HIGH  = 8'hFF;

    // Lexer and parser phases of the predictor.
    typedef enum logic [2:0] {LX_IDLE, LX_NAME, LX_NUM, LX_SIGN, LX_STR} lex_state_t;
    typedef enum logic [1:0] {PH_OPEN, PH_IN, PH_CLOSED, PH_DONE} parse_state_t;

    // One expected result beat, with every field the monitor checks.
    typedef struct {
        kind_t       kind;
        logic [15:0] start_col;
        logic [15:0] token_len;
        logic [7:0]  nest_level;
        err_t        err_code;
        logic        last;
        logic        finished;
    } token_beat_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    sexpr_tokenizer_validator u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Characters waiting to be sent, and the scratch buffer in which one
    // random expression is built before it joins them.
    item_t       char_queue[$];
    logic [7:0]  text_buf[$];
    int unsigned random_chars;

    // Expected result beats, oldest first.
    token_beat_t expected_tokens[$];
    token_beat_t char_results[$];
    int unsigned n_fail;
    int unsigned beat_no;

    // Predictor state: a private copy of everything the block remembers.
    lex_state_t   lx;
    parse_state_t ph;
    int unsigned  col_pos;
    int unsigned  tok_start;
    int unsigned  depth;
    logic         point_seen;
    logic         exp_seen;
    logic [1:0]   look_held;   // 0 nothing, 1 an 'e' held, 2 an 'e' and a sign held
    logic [1:0]   nil_prog;

    //------------------------------------------------------------------
    // Token predictor
    //------------------------------------------------------------------

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == " " || c == CH_TAB || c == CH_NL || c == CH_VT || c == CH_FF;
    endfunction

    function automatic bit is_sign(logic [7:0] c);
        return c == "+" || c == "-";
    endfunction

    function automatic void clear_predictor();
        lx         = LX_IDLE;
        ph         = PH_OPEN;
        col_pos    = 0;
        tok_start  = 0;
        depth      = 0;
        point_seen = 1'b0;
        exp_seen   = 1'b0;
        look_held  = 2'd0;
        nil_prog   = 2'd0;
    endfunction

    // A single character never causes more than MAX_RES results; anything
    // past that is dropped, as the block has no room for it.
    function automatic void add_result(kind_t k, int unsigned col, int unsigned len,
                                       err_t e, logic fin);
        token_beat_t r;
        if (char_results.size() >= MAX_RES)
            return;
        r.kind       = k;
        r.start_col  = col[15:0];
        r.token_len  = len[15:0];
        r.nest_level = (k == K_EOF) ? 8'd0 : depth[7:0];
        r.err_code   = e;
        r.last       = 1'b0;
        r.finished   = fin;
        char_results.push_back(r);
    endfunction

    // Only the first error of an expression is reported.
    function automatic void raise_error(err_t e, int unsigned col);
        if (ph == PH_DONE)
            return;
        add_result(K_ERROR, col, 0, e, 1'b1);
        ph = PH_DONE;
    endfunction

    function automatic void accept_token(kind_t k, int unsigned col, int unsigned len);
        if (ph != PH_IN)
            return;
        if (k == K_LPAREN) begin
            if (depth >= MAX_DEPTH) begin
                raise_error(E_TOO_DEEP, col);
                return;
            end
            depth++;
        end else if (k == K_RPAREN) begin
            if (depth > 0)
                depth--;
            if (depth == 0)
                ph = PH_CLOSED;
        end
        add_result(k, col, len, E_NONE, 1'b0);
    endfunction

    function automatic void number_token(int unsigned end_col);
        accept_token((point_seen || exp_seen) ? K_REAL : K_INTEGER, tok_start,
                     end_col - tok_start);
    endfunction

    // Feeds one character to the lexer. A character that ends a token is
    // looked at again in the new lexer phase, hence the loop.
    function automatic void lex_char(logic [7:0] c, int unsigned col);
        bit again;
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            if (ph != PH_IN)
                return;
            case (lx)
                LX_IDLE: begin
                    if (is_blank(c)) begin
                    end else if (c == "(") begin
                        accept_token(K_LPAREN, col, 1);
                    end else if (c == ")") begin
                        accept_token(K_RPAREN, col, 1);
                    end else begin
                        tok_start = col;
                        if (is_alpha(c)) begin
                            lx       = LX_NAME;
                            nil_prog = (c == "n") ? 2'd1 : 2'd0;
                        end else if (is_digit(c)) begin
                            lx         = LX_NUM;
                            point_seen = 1'b0;
                            exp_seen   = 1'b0;
                            look_held  = 2'd0;
                        end else if (c == CH_QUOTE) begin
                            lx = LX_STR;
                        end else if (is_sign(c)) begin
                            lx = LX_SIGN;
                        end else begin
                            raise_error(E_BAD_CHAR, col);
                        end
                    end
                end
                LX_NAME: begin
                    if (is_alpha(c) || is_digit(c) || c == "_") begin
                        if (nil_prog == 2'd1 && c == "i")
                            nil_prog = 2'd2;
                        else if (nil_prog == 2'd2 && c == "l")
                            nil_prog = 2'd3;
                        else
                            nil_prog = 2'd0;
                    end else begin
                        lx = LX_IDLE;
                        accept_token((nil_prog == 2'd3) ? K_NIL : K_NAME, tok_start,
                                     col - tok_start);
                        again = 1'b1;
                    end
                end
                LX_SIGN: begin
                    if (is_digit(c) || c == ".") begin
                        lx         = LX_NUM;
                        point_seen = (c == ".");
                        exp_seen   = 1'b0;
                        look_held  = 2'd0;
                    end else begin
                        raise_error(E_BAD_CHAR, tok_start);
                    end
                end
                LX_STR: begin
                    if (c == CH_QUOTE) begin
                        lx = LX_IDLE;
                        accept_token(K_STRING, tok_start, col - tok_start - 1);
                    end
                end
                default: begin
                    if (look_held == 2'd1) begin
                        // An 'e' is held: a digit makes it an exponent, a sign
                        // defers the decision, anything else turns it into a name.
                        if (is_digit(c)) begin
                            exp_seen  = 1'b1;
                            look_held = 2'd0;
                        end else if (is_sign(c)) begin
                            look_held = 2'd2;
                        end else begin
                            look_held = 2'd0;
                            number_token(col - 1);
                            lx        = LX_NAME;
                            tok_start = col - 1;
                            nil_prog  = 2'd0;
                            again     = 1'b1;
                        end
                    end else if (look_held == 2'd2) begin
                        if (is_digit(c)) begin
                            exp_seen  = 1'b1;
                            look_held = 2'd0;
                        end else begin
                            // The 'e' becomes a one-letter name, the sign starts anew.
                            look_held = 2'd0;
                            number_token(col - 2);
                            accept_token(K_NAME, col - 2, 1);
                            lx        = LX_SIGN;
                            tok_start = col - 1;
                            again     = 1'b1;
                        end
                    end else if (is_digit(c)) begin
                    end else if (c == ".") begin
                        if (point_seen || exp_seen)
                            raise_error(E_EXTRA_POINT, col);
                        else
                            point_seen = 1'b1;
                    end else if ((c == "e" || c == "E") && !exp_seen) begin
                        look_held = 2'd1;
                    end else begin
                        lx = LX_IDLE;
                        number_token(col);
                        again = 1'b1;
                    end
                end
            endcase
        end
    endfunction

    // Reports whatever token is still open when the end mark arrives.
    function automatic void flush_token(int unsigned col);
        case (lx)
            LX_NAME: accept_token((nil_prog == 2'd3) ? K_NIL : K_NAME, tok_start,
                                  col - tok_start);
            LX_SIGN: raise_error(E_BAD_CHAR, tok_start);
            LX_STR:  raise_error(E_OPEN_STRING, tok_start);
            LX_NUM: begin
                if (look_held == 2'd1) begin
                    number_token(col - 1);
                    accept_token(K_NAME, col - 1, 1);
                end else if (look_held == 2'd2) begin
                    number_token(col - 2);
                    accept_token(K_NAME, col - 2, 1);
                    raise_error(E_BAD_CHAR, col - 1);
                end else begin
                    number_token(col);
                end
            end
            default: ;
        endcase
        lx = LX_IDLE;
    endfunction

    // Works out the result beats of one accepted input beat and queues them.
    function automatic void tokenize_char(logic [7:0] c, logic end_mark);
        token_beat_t r;
        char_results.delete();
        if (end_mark) begin
            case (ph)
                PH_OPEN: raise_error(E_NO_OPEN, col_pos);
                PH_IN: begin
                    flush_token(col_pos);
                    if (ph == PH_IN)
                        raise_error(E_MISSING_CLOSE, col_pos);
                end
                PH_CLOSED: add_result(K_EOF, col_pos, 0, E_NONE, 1'b1);
                default: ;
            endcase
            clear_predictor();
        end else if (ph != PH_DONE) begin
            if (col_pos >= MAX_POSITION) begin
                // Too long: the open token is not flushed.
                raise_error(E_TOO_LONG, col_pos);
            end else begin
                if (ph == PH_OPEN) begin
                    if (c == "(") begin
                        depth = 1;
                        ph    = PH_IN;
                        add_result(K_LPAREN, col_pos, 1, E_NONE, 1'b0);
                    end else if (!is_blank(c)) begin
                        raise_error(E_NO_OPEN, col_pos);
                    end
                end else if (ph == PH_IN) begin
                    lex_char(c, col_pos);
                end else if (!is_blank(c)) begin
                    raise_error(E_TRAILING, col_pos);
                end
                col_pos++;
            end
        end
        if (char_results.size() > 0) begin
            r = char_results.pop_back();
            r.last = 1'b1;
            char_results.push_back(r);
        end
        foreach (char_results[i])
            expected_tokens.push_back(char_results[i]);
    endfunction

    //------------------------------------------------------------------
    // Stimulus building
    //------------------------------------------------------------------

    function automatic void push_char(logic [7:0] b);
        item_t it;
        it.ch       = b;
        it.end_mark = 1'b0;
        char_queue.push_back(it);
    endfunction

    // The byte beside an end mark is ignored, so it is random.
    function automatic void push_end_mark();
        item_t it;
        it.ch       = 8'($urandom_range(255, 0));
        it.end_mark = 1'b1;
        char_queue.push_back(it);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endfunction

    function automatic logic [7:0] any_blank();
        case ($urandom_range(4, 0))
            0:       return " ";
            1:       return CH_TAB;
            2:       return CH_NL;
            3:       return CH_VT;
            default: return CH_FF;
        endcase
    endfunction

    function automatic logic [7:0] any_letter();
        logic [7:0] base;
        base = $urandom_range(1, 0) ? "a" : "A";
        return base + 8'($urandom_range(25, 0));
    endfunction

    function automatic logic [7:0] any_digit();
        return "0" + 8'($urandom_range(9, 0));
    endfunction

    // Six cases in ten give a byte the lexer has rules for, the rest give any byte.
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(9, 0))
            0:       return ".";
            1:       return $urandom_range(1, 0) ? "+" : "-";
            2:       return $urandom_range(1, 0) ? "e" : "E";
            3:       return CH_QUOTE;
            4:       return $urandom_range(1, 0) ? "(" : ")";
            5:       return CH_CR;
            default: return 8'($urandom_range(255, 0));
        endcase
    endfunction

    function automatic void add_gap();
        int unsigned n;
        n = $urandom_range(2, 0);
        if (n == 0 && $urandom_range(3, 0) != 0)
            n = 1;
        repeat (n) text_buf.push_back(any_blank());
    endfunction

    function automatic void add_digits(int unsigned lo, int unsigned hi);
        repeat ($urandom_range(hi, lo)) text_buf.push_back(any_digit());
    endfunction

    function automatic void add_sign();
        if ($urandom_range(2, 0) == 0)
            text_buf.push_back($urandom_range(1, 0) ? "+" : "-");
    endfunction

    function automatic void add_atom();
        logic [7:0] b;
        case ($urandom_range(5, 0))
            0: begin
                text_buf.push_back(any_letter());
                repeat ($urandom_range(5, 0)) begin
                    case ($urandom_range(3, 0))
                        0:       text_buf.push_back(any_digit());
                        1:       text_buf.push_back("_");
                        default: text_buf.push_back(any_letter());
                    endcase
                end
            end
            1: begin
                // The keyword and names that only start like it.
                text_buf.push_back("n");
                if ($urandom_range(3, 0) != 0) text_buf.push_back("i");
                if ($urandom_range(3, 0) != 0) text_buf.push_back("l");
                if ($urandom_range(3, 0) == 0) text_buf.push_back(any_letter());
            end
            2: begin
                add_sign();
                add_digits(1, 5);
            end
            3: begin
                add_sign();
                add_digits(1, 3);
                if ($urandom_range(1, 0)) begin
                    text_buf.push_back(".");
                    add_digits(0, 3);
                end
                if ($urandom_range(1, 0)) begin
                    text_buf.push_back($urandom_range(1, 0) ? "e" : "E");
                    add_sign();
                    add_digits(1, 2);
                end
            end
            4: begin
                text_buf.push_back(CH_QUOTE);
                repeat ($urandom_range(6, 0)) begin
                    do b = 8'($urandom_range(255, 0)); while (b == CH_QUOTE);
                    text_buf.push_back(b);
                end
                text_buf.push_back(CH_QUOTE);
            end
            default: begin
                // A number followed by an 'e' that turns out not to be an exponent.
                add_digits(1, 3);
                text_buf.push_back($urandom_range(1, 0) ? "e" : "E");
                if ($urandom_range(1, 0))
                    text_buf.push_back($urandom_range(1, 0) ? "+" : "-");
                if ($urandom_range(1, 0))
                    text_buf.push_back(any_letter());
            end
        endcase
    endfunction

    function automatic void add_list(int unsigned lvl);
        text_buf.push_back("(");
        repeat ($urandom_range(4, 0)) begin
            add_gap();
            if (lvl < 3 && $urandom_range(3, 0) == 0)
                add_list(lvl + 1);
            else
                add_atom();
        end
        add_gap();
        text_buf.push_back(")");
    endfunction

    // One expression of random content. Half are left as built; the others get a
    // stray byte, lose a byte to noise, are cut short, or carry leading or trailing junk.
    function automatic void add_random_expr();
        int unsigned idx;
        text_buf.delete();
        if ($urandom_range(3, 0) == 0)
            text_buf.push_back(any_blank());
        add_list(0);
        if ($urandom_range(1, 0))
            text_buf.push_back(any_blank());
        idx = $urandom_range(text_buf.size() - 1, 0);
        case ($urandom_range(9, 0))
            0: text_buf.insert(idx, noise_byte());
            1: while (text_buf.size() > idx + 1) void'(text_buf.pop_back());
            2: text_buf.push_back(noise_byte());
            3: text_buf[idx] = noise_byte();
            4: text_buf.push_front(noise_byte());
            default: ;
        endcase
        foreach (text_buf[i])
            push_char(text_buf[i]);
        random_chars += text_buf.size();
        push_end_mark();
    endfunction

    // A short text followed by its end mark.
    function automatic void add_directed(string s);
        push_text(s);
        push_end_mark();
    endfunction

    function automatic void build_stimulus();
        // Every token kind, a signed real, an 'e' that is not an exponent,
        // a name running into a string, and white space after the close.
        add_directed("(nil -1.5e3 9e x\"q\")\t\n");
        // Exponent after an exponent, a signed point-first real, near-keywords.
        add_directed("( 12e+3E4 +.5 ni nils 7E-2)");
        // A held 'e' and sign with no digit after them.
        add_directed("(1e+x");
        add_directed("( 1e-");
        // End of text while nested, with and without a pending token.
        add_directed("(ab 12e");
        add_directed("((a)");
        add_directed("(");
        // A string holding the extreme bytes, then a second point.
        push_text("(\"");
        push_char(CH_HIGH);
        push_char(CH_NUL);
        add_directed("\" 1.2.3");
        add_directed("(2.e5.)");
        // Before the opening parenthesis and after the closing one.
        add_directed(" x");
        push_end_mark();
        add_directed("()  z");
        add_directed("(\"ab");
        push_text("(a");
        push_char(CH_CR);
        push_end_mark();
        add_directed("(+)");
        push_text("(");
        push_char(CH_NUL);
        push_end_mark();

        // Nesting one level deeper than allowed.
        repeat (MAX_DEPTH + 1) push_char("(");
        add_directed(")");

        while (random_chars < RANDOM_ITEMS)
            add_random_expr();
    endfunction

    //------------------------------------------------------------------
    // Driver: bursts of beats with random gaps between them
    //------------------------------------------------------------------

    item_t       drv_item;
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= 8'h00;
            s_tlast    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            // The predictor sees each character in the cycle it is taken.
            if (s_tvalid && s_tready)
                tokenize_char(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (char_queue.size() > 0) begin
                    drv_item = char_queue.pop_front();
                    s_tdata  <= drv_item.ch;
                    s_tlast  <= drv_item.end_mark;
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        // Half of the bursts run straight into the next one.
                        burst_left <= $urandom_range(40, 1);
                        gap_left   <= $urandom_range(1, 0) ? 0 : $urandom_range(6, 1);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Receiver: a stall pattern picked at random from four modes, and a long hold
    // now and then so that both registers fill and s_tready drops.
    //------------------------------------------------------------------

    int unsigned rx_cycle;
    int unsigned hold_left;
    int unsigned rx_mode;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            rx_cycle  <= 0;
            hold_left <= 0;
            rx_mode   <= 0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 64 == 0)
                rx_mode <= $urandom_range(3, 0);
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (rx_cycle % HOLD_PERIOD == HOLD_PERIOD / 6) begin
                hold_left <= LONG_HOLD;
                m_tready  <= 1'b0;
            end else begin
                case (rx_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(1, 0) == 0);
                    2:       m_tready <= ($urandom_range(2, 0) == 0);
                    default: m_tready <= rx_cycle[2];
                endcase
            end
        end
    end

    //------------------------------------------------------------------
    // Monitor
    //------------------------------------------------------------------

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        n_fail++;
        if (n_fail <= MAX_REPORTS)
            $display("%0t ns: result beat %0d: %s is %0d, expected %0d",
                     $time, beat_no, what, got, want);
    endtask

    token_beat_t mon_want;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch("beat with nothing expected, kind", m_tuser, 0);
            end else begin
                mon_want = expected_tokens.pop_front();
                if (m_tuser !== mon_want.kind)
                    report_mismatch("kind", m_tuser, mon_want.kind);
                if (m_tdata[15:0] !== mon_want.start_col)
                    report_mismatch("start_col", m_tdata[15:0], mon_want.start_col);
                if (m_tdata[31:16] !== mon_want.token_len)
                    report_mismatch("token_len", m_tdata[31:16], mon_want.token_len);
                if (m_tdata[39:32] !== mon_want.nest_level)
                    report_mismatch("nest_level", m_tdata[39:32], mon_want.nest_level);
                if (m_tdata[43:40] !== mon_want.err_code)
                    report_mismatch("err_code", m_tdata[43:40], mon_want.err_code);
                if (m_tdata[44] !== mon_want.finished)
                    report_mismatch("finished", m_tdata[44], mon_want.finished);
                if (m_tdata[47:45] !== 3'd0)
                    report_mismatch("pad bits", m_tdata[47:45], 0);
                if (m_tlast !== mon_want.last)
                    report_mismatch("last", m_tlast, mon_want.last);
            end
            beat_no++;
        end
    end

    //------------------------------------------------------------------
    // Watchdog: ends a run that has stopped moving.
    //------------------------------------------------------------------

    int unsigned quiet_cycles;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL sexpr_tokenizer_validator");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    //------------------------------------------------------------------
    // Sequence of the run
    //------------------------------------------------------------------

    initial begin
        n_fail       = 0;
        beat_no      = 0;
        random_chars = 0;
        clear_predictor();
        build_stimulus();

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Polling on the falling edge keeps clear of the clocked processes.
        while (char_queue.size() > 0 || s_tvalid)
            @(negedge aclk);
        while (expected_tokens.size() > 0)
            @(negedge aclk);
        // Let any stray beat show up before the verdict.
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (n_fail == 0 && expected_tokens.size() == 0) begin
            $display("PASS sexpr_tokenizer_validator");
        end else begin
            $display("FAIL sexpr_tokenizer_validator");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/stv_pkg.sv
design/stv_in_stage.sv
design/stv_lexer.sv
design/stv_out_stage.sv
design/sexpr_tokenizer_validator.sv
tb/tb_sexpr_tokenizer_validator.sv
